@@ rtl/core/bicd_pkg.sv @@
// Shared widths, reset values and register codes for the block index dedup core.
`default_nettype none

package bicd_pkg;

   localparam int PIDX_W     = 20;   // point index
   localparam int BSIZE_W    = 9;    // block size register
   localparam int LIMIT_W    = 20;   // index limit register
   localparam int BIDX_W     = 12;   // block index on the result word
   localparam int COUNT_W    = 13;   // unique count
   localparam int EPOCH_W    = 8;    // set tag kept per bitmap entry
   localparam int STEP_W     = $clog2(PIDX_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   localparam int MAX_BLOCKS_DEF = 4096;

   localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(1);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(4096);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE  = 1'b0,
      CSR_INDEX_LIMIT = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

@@ rtl/core/bicd_if.sv @@
// Request and response channel interfaces of the block index dedup core.
`default_nettype none

interface bicd_req_if;
   logic                        valid;
   logic                        ready;
   logic [bicd_pkg::PIDX_W-1:0] point_index;
   logic                        start_of_set;
   logic                        end_of_set;

   modport source (output valid, point_index, start_of_set, end_of_set, input ready);
   modport sink   (input valid, point_index, start_of_set, end_of_set, output ready);
endinterface

interface bicd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bicd_pkg::BIDX_W-1:0]  block_index;
   logic                         is_new;
   logic [bicd_pkg::COUNT_W-1:0] unique_count;
   logic                         set_done;
   logic                         out_of_range;

   modport source (output valid, block_index, is_new, unique_count, set_done, out_of_range,
                   input ready);
   modport sink   (input valid, block_index, is_new, unique_count, set_done, out_of_range,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/bicd_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bicd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/block_index_compress_dedup.sv @@
// Top level: block index dedup with iterative divider and set-tagged seen bitmap.
//
//   port group   dir   handshake        contents
//   req_bus      in    valid/ready      point_index, start_of_set, end_of_set
//   rsp_bus      out   valid/ready      block_index, is_new, unique_count, set_done,
//                                       out_of_range
//   csr_*        in    write enable     csr_index (0 block_size, 1 index_limit), csr_write_data
//
// Per word: accept, 20 steps of the restore-divide unit (one quotient bit per step),
//   bitmap lookup, bitmap update, result load.
// Reset: a clearing pass writes every bitmap entry while req is not ready.
// Each set start bumps an 8-bit set tag instead of clearing; when the tag wraps, the
//   same clearing pass runs first (once every 255 sets).
// Stalls: the result sits in an output register; the next word is taken while it waits.
`default_nettype none

module block_index_compress_dedup #(
   parameter int MAX_BLOCKS = bicd_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bicd_req_if.sink                               req_bus,
   bicd_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_write_enable,
   input  wire logic [bicd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bicd_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int PW = bicd_pkg::PIDX_W;
   localparam int DW = bicd_pkg::BSIZE_W;
   localparam int EW = bicd_pkg::EPOCH_W;
   localparam int CW = bicd_pkg::COUNT_W;
   localparam logic [PW:0]   BLK_LIMIT = (PW+1)'(MAX_BLOCKS);
   localparam logic [AW-1:0] CLR_LAST  = AW'(MAX_BLOCKS - 1);
   localparam logic [bicd_pkg::STEP_W-1:0] STEP_LAST = bicd_pkg::STEP_W'(PW - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_LOOKUP,
      ST_UPDATE,
      ST_DELIVER
   } state_type;

   // config
   logic [DW-1:0]                    bsize_ff, bsize_in;
   logic [bicd_pkg::LIMIT_W-1:0]     limit_ff, limit_in;

   // sequencer and item
   state_type                        state_ff, state_in;
   logic [PW-1:0]                    pidx_ff, pidx_in;
   logic                             end_ff, end_in;
   logic                             pend_ff, pend_in;     // word waiting behind clear pass
   logic [AW-1:0]                    clr_addr_ff, clr_addr_in;
   logic [EW-1:0]                    epoch_ff, epoch_in;
   logic [CW-1:0]                    count_ff, count_in;

   // divider
   logic [PW-1:0]                    quo_ff, quo_in;       // dividend in, quotient out
   logic [DW-1:0]                    rem_ff, rem_in;
   logic [bicd_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [DW:0]                      trial;
   logic                             trial_ge;
   logic [DW-1:0]                    divisor;

   logic                             oor_ff, oor_in;
   logic                             fresh_ff, fresh_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bicd_pkg::BIDX_W-1:0]      rsp_bidx_ff, rsp_bidx_in;
   logic                             rsp_new_ff, rsp_new_in;
   logic [CW-1:0]                    rsp_count_ff, rsp_count_in;
   logic                             rsp_done_ff, rsp_done_in;
   logic                             rsp_oor_ff, rsp_oor_in;

   // bitmap
   logic                             ram_wr_en;
   logic [AW-1:0]                    ram_wr_addr;
   logic [EW-1:0]                    ram_wr_data;
   logic                             ram_rd_en;
   logic [EW-1:0]                    ram_rd_data;

   logic                             req_take;
   logic                             rsp_free;
   logic [DW-1:0]                    gap;
   logic [PW:0]                      limit_sum;
   logic                             seen_hit;

   assign divisor  = (bsize_ff == '0) ? DW'(1) : bsize_ff;
   assign req_take = req_bus.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, quo_ff[PW-1]};
   assign trial_ge = trial >= {1'b0, divisor};

   // q >= limit/d  <=>  (q+1)*d > limit  <=>  p + (d - r) > limit
   assign gap       = divisor - rem_ff;
   assign limit_sum = {1'b0, pidx_ff} + {{(PW+1-DW){1'b0}}, gap};
   assign seen_hit  = (ram_rd_data == epoch_ff);

   always_comb begin
      bsize_in     = bsize_ff;
      limit_in     = limit_ff;
      state_in     = state_ff;
      pidx_in      = pidx_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      clr_addr_in  = clr_addr_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      oor_in       = oor_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bidx_in  = rsp_bidx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_count_in = rsp_count_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_oor_in   = rsp_oor_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = quo_ff[AW-1:0];
      ram_wr_data  = epoch_ff;
      ram_rd_en    = 1'b0;

      if (csr_write_enable) begin
         unique case (bicd_pkg::csr_index_type'(csr_index))
            bicd_pkg::CSR_BLOCK_SIZE:  bsize_in = csr_write_data[DW-1:0];
            bicd_pkg::CSR_INDEX_LIMIT: limit_in = csr_write_data[bicd_pkg::LIMIT_W-1:0];
         endcase
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = bicd_pkg::EPOCH_NONE;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == CLR_LAST) begin
               clr_addr_in = '0;
               epoch_in    = bicd_pkg::EPOCH_FIRST;
               pend_in     = 1'b0;
               state_in    = pend_ff ? ST_DIV : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               pidx_in = req_bus.point_index;
               end_in  = req_bus.end_of_set;
               quo_in  = req_bus.point_index;
               rem_in  = '0;
               step_in = '0;
               state_in = ST_DIV;
               if (req_bus.start_of_set) begin
                  count_in = '0;
                  if (epoch_ff == bicd_pkg::EPOCH_LAST) begin
                     pend_in  = 1'b1;
                     state_in = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EW'(1);
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            quo_in  = {quo_ff[PW-2:0], trial_ge};
            step_in = step_ff + bicd_pkg::STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ram_rd_en = 1'b1;
            oor_in    = (limit_sum > {1'b0, limit_ff}) || ({1'b0, quo_ff} >= BLK_LIMIT);
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            fresh_in  = !oor_ff && !seen_hit;
            ram_wr_en = !oor_ff && !seen_hit;
            if (!oor_ff && !seen_hit && (count_ff != bicd_pkg::COUNT_MAX)) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bidx_in  = quo_ff[bicd_pkg::BIDX_W-1:0];
               rsp_new_in   = fresh_ff;
               rsp_count_in = count_ff;
               rsp_done_in  = end_ff;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bsize_ff     <= bicd_pkg::BSIZE_RST;
         limit_ff     <= bicd_pkg::LIMIT_RST;
         pend_ff      <= 1'b0;
         clr_addr_ff  <= '0;
         epoch_ff     <= bicd_pkg::EPOCH_FIRST;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bsize_ff     <= bsize_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         clr_addr_ff  <= clr_addr_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff      <= pidx_in;
      end_ff       <= end_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      oor_ff       <= oor_in;
      fresh_ff     <= fresh_in;
      rsp_bidx_ff  <= rsp_bidx_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_count_ff <= rsp_count_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   // seen bitmap: each entry holds the tag of the last set that recorded it
   bicd_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_BLOCKS)
   ) u_seen_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (quo_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.block_index  = rsp_bidx_ff;
   assign rsp_bus.is_new       = rsp_new_ff;
   assign rsp_bus.unique_count = rsp_count_ff;
   assign rsp_bus.set_done     = rsp_done_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire
